// ===== src/ipv4cf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4cf_pkg: shared types and constants of the IPv4 checksum filler
// Status codes, protocol numbers, the per-packet summary handed from the
// parser to the finisher, and protocol lookup helpers.
// ----------------------------------------------------------------------------
package ipv4cf_pkg;

   localparam logic [16:0] MAX_LEN    = 17'd65535;  // longest packet handled
   localparam logic [16:0] COUNT_MAX  = 17'h1ffff;  // byte counter saturates here
   localparam logic [5:0]  MIN_HDR    = 6'd20;      // shortest legal header
   localparam logic [16:0] MIN_PKT    = 17'd20;

   localparam logic [7:0] PROTO_ICMP = 8'd1;
   localparam logic [7:0] PROTO_TCP  = 8'd6;
   localparam logic [7:0] PROTO_UDP  = 8'd17;

   localparam logic [4:0] OFF_TCP  = 5'd16;
   localparam logic [4:0] OFF_UDP  = 5'd6;
   localparam logic [4:0] OFF_ICMP = 5'd2;

   localparam logic [15:0] NEED_TCP  = 16'd20;
   localparam logic [15:0] NEED_UDP  = 16'd8;
   localparam logic [15:0] NEED_ICMP = 16'd4;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_MALFORMED = 2'd1,
      STATUS_OVERSIZE  = 2'd2
   } status_type;

   // Everything the finisher needs about one packet
   typedef struct packed {
      logic [16:0] len;
      logic        version_ok;
      logic [5:0]  header_len;
      logic        fragment;
      logic [7:0]  protocol;
      logic        ip_field_zero;
      logic        l4_field_zero;
      logic [20:0] header_sum;
      logic [31:0] transport_sum;
   } summary_type;

   typedef struct packed {
      status_type  status;
      logic        ip_write;
      logic [15:0] ip_checksum;
      logic        l4_write;
      logic [6:0]  l4_offset;
      logic [15:0] l4_checksum;
   } result_type;

   function automatic logic proto_known(input logic [7:0] proto);
      proto_known = (proto == PROTO_TCP) || (proto == PROTO_UDP) || (proto == PROTO_ICMP);
   endfunction

   function automatic logic uses_pseudo(input logic [7:0] proto);
      uses_pseudo = (proto == PROTO_TCP) || (proto == PROTO_UDP);
   endfunction

   // Offset of the transport checksum inside the transport part
   function automatic logic [4:0] l4_field_off(input logic [7:0] proto);
      logic [4:0] off;
      off = 5'd0;
      case (proto)
         PROTO_TCP:  off = OFF_TCP;
         PROTO_UDP:  off = OFF_UDP;
         PROTO_ICMP: off = OFF_ICMP;
         default:    off = 5'd0;
      endcase
      l4_field_off = off;
   endfunction

   function automatic logic [15:0] l4_min_len(input logic [7:0] proto);
      logic [15:0] need;
      need = NEED_ICMP;
      case (proto)
         PROTO_TCP: need = NEED_TCP;
         PROTO_UDP: need = NEED_UDP;
         default:   need = NEED_ICMP;
      endcase
      l4_min_len = need;
   endfunction

endpackage

// ===== src/ipv4cf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4cf_front: byte parser and running sums
// Takes one packet byte per transaction, captures header fields and keeps
// header and transport word sums; hands a summary over on the last byte.
// ----------------------------------------------------------------------------
module ipv4cf_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     byte_valid,
   input  logic [7:0]               data_byte,
   input  logic                     last_byte,
   output logic                     sum_push,
   output ipv4cf_pkg::summary_type  sum_data
);

   logic [16:0] count_ff, count_in;
   logic [5:0]  hl_ff, hl_in;
   logic        ver_ff, ver_in;
   logic        frag_ff, frag_in;
   logic [7:0]  proto_ff, proto_in;
   logic        ipz_ff, ipz_in;
   logic        l4z_ff, l4z_in;
   logic [7:0]  hb_ff, hb_in;
   logic [20:0] hsum_ff, hsum_in;
   logic [31:0] tsum_ff, tsum_in;

   logic [16:0] pos, word_pos;
   logic        in_range, odd, add_en;
   logic [15:0] word;
   logic [6:0]  tgt0, tgt1;

   // Next values as if this byte were taken; the registers clear on the last byte
   logic [5:0]  hl_n;
   logic        ver_n, frag_n, ipz_n, l4z_n;
   logic [7:0]  proto_n, hb_n;
   logic [20:0] hsum_n;
   logic [31:0] tsum_n;

   always_comb begin
      pos      = count_ff;
      in_range = pos < ipv4cf_pkg::MAX_LEN;
      odd      = pos[0];
      word_pos = {pos[16:1], 1'b0};
      word     = odd ? {hb_ff, data_byte} : {data_byte, 8'd0};
      add_en   = in_range && (odd || last_byte);

      hl_n = hl_ff; ver_n = ver_ff; frag_n = frag_ff; proto_n = proto_ff;
      ipz_n = ipz_ff; l4z_n = l4z_ff; hb_n = hb_ff;
      hsum_n = hsum_ff; tsum_n = tsum_ff;

      tgt0 = {1'b0, hl_ff} + {2'b00, ipv4cf_pkg::l4_field_off(proto_ff)};
      tgt1 = tgt0 + 7'd1;

      if (in_range) begin
         if (pos == 17'd0) begin
            ver_n = data_byte[7:4] == 4'd4;
            hl_n  = {data_byte[3:0], 2'b00};
         end
         if (pos == 17'd6) frag_n = data_byte[4:0] != 5'd0;
         if (pos == 17'd7) frag_n = frag_ff || (data_byte != 8'd0);
         if (pos == 17'd9) proto_n = data_byte;
         if (pos == 17'd10) ipz_n = data_byte == 8'd0;
         if (pos == 17'd11) ipz_n = ipz_ff && (data_byte == 8'd0);
         if ((hl_ff >= ipv4cf_pkg::MIN_HDR) && ipv4cf_pkg::proto_known(proto_ff)) begin
            if (pos == {10'd0, tgt0}) l4z_n = data_byte == 8'd0;
            if (pos == {10'd0, tgt1}) l4z_n = l4z_ff && (data_byte == 8'd0);
         end
         if (!odd) hb_n = data_byte;
      end

      if (add_en) begin
         if (word_pos < {11'd0, hl_n}) hsum_n = hsum_ff + {5'd0, word};
         else                          tsum_n = tsum_ff + {16'd0, word};
         // pseudo-header: source and destination addresses
         if (ipv4cf_pkg::uses_pseudo(proto_n) && word_pos >= 17'd12 && word_pos < 17'd20)
            tsum_n = tsum_n + {16'd0, word};
      end
   end

   always_comb begin
      sum_push = byte_valid && last_byte;
      sum_data.len           = count_in;
      sum_data.version_ok    = ver_n;
      sum_data.header_len    = hl_n;
      sum_data.fragment      = frag_n;
      sum_data.protocol      = proto_n;
      sum_data.ip_field_zero = ipz_n;
      sum_data.l4_field_zero = l4z_n;
      sum_data.header_sum    = hsum_n;
      sum_data.transport_sum = tsum_n;
   end

   always_comb begin
      count_in = (count_ff < ipv4cf_pkg::COUNT_MAX) ? count_ff + 17'd1 : count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset || (byte_valid && last_byte)) begin
         count_ff <= '0; hl_ff <= '0; ver_ff <= 1'b0; frag_ff <= 1'b0;
         proto_ff <= '0; ipz_ff <= 1'b0; l4z_ff <= 1'b0; hb_ff <= '0;
         hsum_ff <= '0; tsum_ff <= '0;
      end else if (byte_valid) begin
         count_ff <= count_in; hl_ff <= hl_in; ver_ff <= ver_in; frag_ff <= frag_in;
         proto_ff <= proto_in; ipz_ff <= ipz_in; l4z_ff <= l4z_in; hb_ff <= hb_in;
         hsum_ff <= hsum_in; tsum_ff <= tsum_in;
      end
   end

   assign hl_in    = hl_n;
   assign ver_in   = ver_n;
   assign frag_in  = frag_n;
   assign proto_in = proto_n;
   assign ipz_in   = ipz_n;
   assign l4z_in   = l4z_n;
   assign hb_in    = hb_n;
   assign hsum_in  = hsum_n;
   assign tsum_in  = tsum_n;

endmodule

// ===== src/ipv4cf_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4cf_queue: short summary queue
// Decouples the byte parser from the finisher so each side stalls alone.
// ----------------------------------------------------------------------------
module ipv4cf_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  ipv4cf_pkg::summary_type  push_data,
   output logic                     full,
   input  logic                     pop,
   output logic                     head_valid,
   output ipv4cf_pkg::summary_type  head_data
);

   ipv4cf_pkg::summary_type slot_ff [ipv4cf_pkg::QUEUE_DEPTH];

   logic [ipv4cf_pkg::QUEUE_AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [ipv4cf_pkg::QUEUE_AW:0]   cnt_ff, cnt_in;

   always_comb begin
      full       = cnt_ff == (ipv4cf_pkg::QUEUE_AW+1)'(ipv4cf_pkg::QUEUE_DEPTH);
      head_valid = cnt_ff != '0;
      head_data  = slot_ff[rd_ff];
      wr_in      = push ? wr_ff + (ipv4cf_pkg::QUEUE_AW)'(1) : wr_ff;
      rd_in      = pop ? rd_ff + (ipv4cf_pkg::QUEUE_AW)'(1) : rd_ff;
      cnt_in     = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + (ipv4cf_pkg::QUEUE_AW+1)'(1);
      if (!push && pop) cnt_in = cnt_ff - (ipv4cf_pkg::QUEUE_AW+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_data;
   end

endmodule

// ===== src/ipv4cf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4cf_back: packet finisher
// Checks a packet summary, adds the pseudo-header length and protocol, folds
// the sums and holds the result in an output register.
// ----------------------------------------------------------------------------
module ipv4cf_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     head_valid,
   input  ipv4cf_pkg::summary_type  head_data,
   output logic                     pop,
   output logic                     out_valid,
   input  logic                     out_ready,
   output ipv4cf_pkg::result_type   out_data
);

   typedef struct packed {
      ipv4cf_pkg::status_type status;
      logic        ip_write;
      logic [16:0] hsum;
      logic        l4_write;
      logic [6:0]  l4_offset;
      logic [16:0] tsum;
      logic        is_udp;
   } mid_type;

   logic                    a_valid_ff, a_valid_in;
   mid_type                 a_ff, a_in;
   logic                    o_valid_ff, o_valid_in;
   ipv4cf_pkg::result_type  o_ff, o_in;
   logic                    o_free, a_move;

   // stage A: checks and first fold
   logic        oversize, malformed, l4_ok;
   logic [15:0] l4len;
   logic [31:0] tsum_full;
   logic [6:0]  off_abs;

   always_comb begin
      oversize  = head_data.len > ipv4cf_pkg::MAX_LEN;
      malformed = (head_data.len < ipv4cf_pkg::MIN_PKT) || !head_data.version_ok ||
                  (head_data.header_len < ipv4cf_pkg::MIN_HDR) ||
                  (head_data.len < {11'd0, head_data.header_len});
      l4len     = head_data.len[15:0] - {10'd0, head_data.header_len};
      l4_ok     = !head_data.fragment && ipv4cf_pkg::proto_known(head_data.protocol) &&
                  head_data.l4_field_zero &&
                  (l4len >= ipv4cf_pkg::l4_min_len(head_data.protocol));
      tsum_full = head_data.transport_sum;
      if (ipv4cf_pkg::uses_pseudo(head_data.protocol))
         tsum_full = head_data.transport_sum + {24'd0, head_data.protocol} + {16'd0, l4len};
      off_abs   = {1'b0, head_data.header_len} +
                  {2'b00, ipv4cf_pkg::l4_field_off(head_data.protocol)};

      a_in.status    = oversize  ? ipv4cf_pkg::STATUS_OVERSIZE :
                       malformed ? ipv4cf_pkg::STATUS_MALFORMED : ipv4cf_pkg::STATUS_OK;
      a_in.ip_write  = !oversize && !malformed && head_data.ip_field_zero;
      a_in.hsum      = {1'b0, head_data.header_sum[15:0]} + {12'd0, head_data.header_sum[20:16]};
      a_in.l4_write  = !oversize && !malformed && l4_ok;
      a_in.l4_offset = off_abs;
      a_in.tsum      = {1'b0, tsum_full[15:0]} + {1'b0, tsum_full[31:16]};
      a_in.is_udp    = head_data.protocol == ipv4cf_pkg::PROTO_UDP;
   end

   // output stage: second fold, complement, UDP zero rule
   logic [15:0] ip_cs, l4_cs;

   always_comb begin
      ip_cs = ~(a_ff.hsum[15:0] + {15'd0, a_ff.hsum[16]});
      l4_cs = ~(a_ff.tsum[15:0] + {15'd0, a_ff.tsum[16]});
      if (a_ff.is_udp && l4_cs == 16'd0) l4_cs = 16'hffff;
      o_in.status      = a_ff.status;
      o_in.ip_write    = a_ff.ip_write;
      o_in.ip_checksum = a_ff.ip_write ? ip_cs : 16'd0;
      o_in.l4_write    = a_ff.l4_write;
      o_in.l4_offset   = a_ff.l4_write ? a_ff.l4_offset : 7'd0;
      o_in.l4_checksum = a_ff.l4_write ? l4_cs : 16'd0;
   end

   // pipeline flow
   always_comb begin
      o_free     = !o_valid_ff || out_ready;
      a_move     = a_valid_ff && o_free;
      pop        = head_valid && (!a_valid_ff || a_move);
      a_valid_in = pop || (a_valid_ff && !a_move);
      o_valid_in = a_move || (o_valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop)    a_ff <= a_in;
      if (a_move) o_ff <= o_in;
   end

   assign out_valid = o_valid_ff;
   assign out_data  = o_ff;

endmodule

// ===== src/ipv4_checksum_filler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_checksum_filler: IPv4 / TCP / UDP / ICMP checksum offload helper
// Reports the header and transport checksums to fill in for a packet that is
// streamed past one byte at a time; the packet itself is not modified.
// ----------------------------------------------------------------------------
// Use:
//  - req_*: one packet byte per transaction, header first; req_tlast marks
//    the final byte. Bytes may follow back to back, one per cycle, while req_tready
//    is high, and the next packet may start in the cycle after a last byte.
//  - rsp_*: exactly one result transaction per packet: status in rsp_tuser,
//    fill flags, checksums and transport checksum offset in rsp_tdata.
//  - Result path: the summary of the last byte's transaction passes the queue write,
//    the check/fold stage and the output register before the result is offered.
//  - Throughput: one byte per cycle with req_tready high, up to one result per
//    cycle with rsp_tready high; the parser updates its sums as each byte is taken.
//  - A stalled result receiver holds the output and check/fold registers,
//    then fills the four-entry summary queue, so up to six finished packets
//    can wait. While the queue is full req_tready is low for every byte and
//    comes back the cycle after a summary leaves the queue.
//  - Reset (synchronous) empties the queue and pipeline and starts a fresh
//    packet at its first byte.
// ----------------------------------------------------------------------------
module ipv4_checksum_filler (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [0] ip_write, [16:1] ip_checksum, [17] l4_write,
                                    // [24:18] l4_offset, [40:25] l4_checksum, rest zero
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   logic                     q_full, q_push, q_pop, q_valid, byte_take;
   ipv4cf_pkg::summary_type  q_in, q_head;
   ipv4cf_pkg::result_type   res;

   // Only a last byte pushes, but holding off all bytes while full keeps the
   // ready path independent of the payload.
   assign req_tready = !q_full;
   assign byte_take  = req_tvalid && req_tready;

   ipv4cf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_take),
      .data_byte  (req_tdata),
      .last_byte  (req_tlast),
      .sum_push   (q_push),
      .sum_data   (q_in)
   );

   ipv4cf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_in),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (q_head)
   );

   ipv4cf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_valid),
      .head_data  (q_head),
      .pop        (q_pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (res)
   );

   assign rsp_tuser = res.status;
   assign rsp_tdata = {7'd0, res.l4_checksum, res.l4_offset, res.l4_write,
                       res.ip_checksum, res.ip_write};

endmodule
